[hdl/r2p_pkg.sv]
// Package for the rectangular-to-polar converter.
// Holds field widths, quadrant codes, the arctangent table and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r2p_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF = 16;
  localparam int GUARD_BITS     = 16;
  localparam int ACC_W          = 32;
  localparam int MAG_W          = 16;
  localparam int ANGLE_W        = 16;
  localparam int QUAD_W         = 3;

  localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_1      = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_2      = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_3      = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_4      = 3'd4;

  localparam logic [ACC_W-1:0] ACC_PI    = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ACC_ROUND = 32'h0000_8000;

  // atan(2^-i), full circle = 2^32
  localparam logic [ACC_W-1:0] ARC_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [ANGLE_W-1:0] angle_over_pi;
    logic [QUAD_W-1:0]  quadrant;
  } result_t;

endpackage

`default_nettype wire

[hdl/r2p_if.sv]
// Valid/ready channel interfaces for the rectangular-to-polar converter.
// Depends on r2p_pkg for the result field widths.
`timescale 1ns / 1ps
`default_nettype none

interface r2p_in_if #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] real_part;
  logic signed [DATA_WIDTH-1:0] imag_part;

  modport source (output valid, real_part, imag_part, input ready);
  modport sink (input valid, real_part, imag_part, output ready);
endinterface

interface r2p_out_if;
  logic                                valid;
  logic                                ready;
  logic [r2p_pkg::MAG_W-1:0]   magnitude;
  logic [r2p_pkg::ANGLE_W-1:0] angle_over_pi;
  logic [r2p_pkg::QUAD_W-1:0]  quadrant;

  modport source (output valid, magnitude, angle_over_pi, quadrant, input ready);
  modport sink (input valid, magnitude, angle_over_pi, quadrant, output ready);
endinterface

`default_nettype wire

[hdl/r2p_front.sv]
// Front end: absolute values, quadrant, CORDIC pre-rotation, sum of squares.
// Three register stages. Depends on r2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2p_front #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   valid_in,
  input  wire logic signed [DATA_WIDTH-1:0]           re,
  input  wire logic signed [DATA_WIDTH-1:0]           im,
  output logic                                        valid,
  output logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] x,
  output logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] y,
  output logic [r2p_pkg::ACC_W-1:0]                   acc,
  output logic [2*DATA_WIDTH-1:0]                     rem,
  output logic [2*DATA_WIDTH-1:0]                     root,
  output logic [r2p_pkg::QUAD_W-1:0]                  quad
);

  localparam int DW = DATA_WIDTH;
  localparam int G  = r2p_pkg::GUARD_BITS;
  localparam int XW = DW + G + 3;
  localparam int SW = 2 * DW;

  logic signed [DW:0]       re_neg, im_neg;
  logic [DW-1:0]            ar_next, ai_next;
  logic signed [XW-1:0]     xs_next, ys_next;
  logic [r2p_pkg::ACC_W-1:0] acc_next;
  logic [r2p_pkg::QUAD_W-1:0] quad_next;
  logic                     re_zero, im_zero;

  logic                     v1, v2;
  logic [DW-1:0]            ar, ai;
  logic signed [XW-1:0]     x1, y1, x2, y2;
  logic [r2p_pkg::ACC_W-1:0] acc1, acc2;
  logic [r2p_pkg::QUAD_W-1:0] quad1, quad2;
  logic [SW-1:0]            sq_re, sq_im;

  assign re_neg  = -{re[DW-1], re};
  assign im_neg  = -{im[DW-1], im};
  assign ar_next = re[DW-1] ? re_neg[DW-1:0] : re;
  assign ai_next = im[DW-1] ? im_neg[DW-1:0] : im;
  assign re_zero = (re == '0);
  assign im_zero = (im == '0);

  always_comb begin
    xs_next  = {{(XW-DW-G){re[DW-1]}}, re, {G{1'b0}}};
    ys_next  = {{(XW-DW-G){im[DW-1]}}, im, {G{1'b0}}};
    acc_next = '0;
    if (re[DW-1]) begin
      xs_next  = -xs_next;
      ys_next  = -ys_next;
      acc_next = r2p_pkg::ACC_PI;
    end
  end

  always_comb begin
    if (re_zero && im_zero) begin
      quad_next = r2p_pkg::QUAD_ORIGIN;
    end else if (!re[DW-1] && !im[DW-1]) begin
      quad_next = r2p_pkg::QUAD_1;
    end else if ((re[DW-1] || re_zero) && !im[DW-1]) begin
      quad_next = r2p_pkg::QUAD_2;
    end else if ((re[DW-1] || re_zero) && (im[DW-1] || im_zero)) begin
      quad_next = r2p_pkg::QUAD_3;
    end else begin
      quad_next = r2p_pkg::QUAD_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= valid_in;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar    <= ar_next;
      ai    <= ai_next;
      x1    <= xs_next;
      y1    <= ys_next;
      acc1  <= acc_next;
      quad1 <= quad_next;
      sq_re <= SW'(ar) * SW'(ar);
      sq_im <= SW'(ai) * SW'(ai);
      x2    <= x1;
      y2    <= y1;
      acc2  <= acc1;
      quad2 <= quad1;
      rem   <= sq_re + sq_im;
      root  <= '0;
      x     <= x2;
      y     <= y2;
      acc   <= acc2;
      quad  <= quad2;
    end
  end

endmodule

`default_nettype wire

[hdl/r2p_cell.sv]
// One cell of the chain: a CORDIC vectoring rotation and one root digit.
// Stages past the rotation count or digit count pass their data on. Depends on r2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2p_cell #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int ITERATIONS = r2p_pkg::ITERATIONS_DEF,
  parameter int STAGE      = 0
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        en,
  input  wire logic                                        valid_in,
  input  wire logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] x_in,
  input  wire logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] y_in,
  input  wire logic [r2p_pkg::ACC_W-1:0]                   acc_in,
  input  wire logic [2*DATA_WIDTH-1:0]                     rem_in,
  input  wire logic [2*DATA_WIDTH-1:0]                     root_in,
  input  wire logic [r2p_pkg::QUAD_W-1:0]                  quad_in,
  output logic                                             valid,
  output logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] x,
  output logic signed [DATA_WIDTH+r2p_pkg::GUARD_BITS+2:0] y,
  output logic [r2p_pkg::ACC_W-1:0]                        acc,
  output logic [2*DATA_WIDTH-1:0]                          rem,
  output logic [2*DATA_WIDTH-1:0]                          root,
  output logic [r2p_pkg::QUAD_W-1:0]                       quad
);

  localparam int XW = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3;
  localparam int SW = 2 * DATA_WIDTH;

  logic signed [XW-1:0]      x_next, y_next;
  logic [r2p_pkg::ACC_W-1:0] acc_next;
  logic [SW-1:0]             rem_next, root_next;

  generate
    if (STAGE < ITERATIONS) begin : g_rot
      logic signed [XW-1:0] xs, ys;
      assign xs = x_in >>> STAGE;
      assign ys = y_in >>> STAGE;
      always_comb begin
        if (!y_in[XW-1]) begin
          x_next   = x_in + ys;
          y_next   = y_in - xs;
          acc_next = acc_in + r2p_pkg::ARC_TABLE[STAGE];
        end else begin
          x_next   = x_in - ys;
          y_next   = y_in + xs;
          acc_next = acc_in - r2p_pkg::ARC_TABLE[STAGE];
        end
      end
    end else begin : g_rot_pass
      assign x_next   = x_in;
      assign y_next   = y_in;
      assign acc_next = acc_in;
    end

    if (STAGE < DATA_WIDTH) begin : g_root
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (DATA_WIDTH - 1 - STAGE));
      logic [SW:0] trial;
      assign trial = {1'b0, root_in} + {1'b0, BIT};
      always_comb begin
        if ({1'b0, rem_in} >= trial) begin
          rem_next  = rem_in - trial[SW-1:0];
          root_next = (root_in >> 1) + BIT;
        end else begin
          rem_next  = rem_in;
          root_next = root_in >> 1;
        end
      end
    end else begin : g_root_pass
      assign rem_next  = rem_in;
      assign root_next = root_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      acc  <= acc_next;
      rem  <= rem_next;
      root <= root_next;
      quad <= quad_in;
    end
  end

endmodule

`default_nettype wire

[hdl/r2p_out.sv]
// Output stage: rounds magnitude and angle, holds the result in an output
// register backed by a skid register. Depends on r2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2p_out #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [r2p_pkg::ACC_W-1:0]    acc,
  input  wire logic [2*DATA_WIDTH-1:0]      rem,
  input  wire logic [2*DATA_WIDTH-1:0]      root,
  input  wire logic [r2p_pkg::QUAD_W-1:0]   quad,
  output logic                              valid,
  input  wire logic                         ready,
  output r2p_pkg::result_t                  data
);

  localparam int SW = 2 * DATA_WIDTH;

  r2p_pkg::result_t          fin;
  r2p_pkg::result_t          skid_data;
  logic                      skid_valid;
  logic [SW-1:0]             rounded;
  logic [r2p_pkg::ACC_W-1:0] acc_rounded;

  assign rounded     = root + SW'(rem > root);
  assign acc_rounded = acc + r2p_pkg::ACC_ROUND;

  always_comb begin
    fin.magnitude     = r2p_pkg::MAG_W'(rounded);
    fin.quadrant      = quad;
    fin.angle_over_pi = acc_rounded[r2p_pkg::ACC_W-1 -: r2p_pkg::ANGLE_W];
    if (quad == r2p_pkg::QUAD_ORIGIN) begin
      fin.angle_over_pi = '0;
    end
  end

  assign up_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (ready || !valid) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= up_valid;
      end
    end else if (up_valid && up_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready || !valid) begin
      data <= skid_valid ? skid_data : fin;
    end else if (up_valid && up_ready) begin
      skid_data <= fin;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> valid)
    else $error("skid register full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(valid && !ready))
    else $error("skid register filled without a stalled output");

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    valid && data.quadrant == r2p_pkg::QUAD_ORIGIN |->
      data.magnitude == '0 && data.angle_over_pi == '0)
    else $error("origin result with nonzero magnitude or angle");

  a_nonorigin_mag: assert property (@(posedge clk) disable iff (rst)
    valid && data.quadrant != r2p_pkg::QUAD_ORIGIN && DATA_WIDTH <= 16 |->
      data.magnitude != '0)
    else $error("nonzero input gave zero magnitude");

endmodule

`default_nettype wire

[hdl/rect_to_polar.sv]
// Rectangular-to-polar converter: exact rounded magnitude, CORDIC argument in units of pi.
// Pipeline: three front stages, one cell per CORDIC rotation / root digit, one output register.
// Throughput: one transfer per cycle; the chain stalls only when the skid register is full.
// Reset clears the valid bits of every stage and of the output and skid registers.
`timescale 1ns / 1ps
`default_nettype none

module rect_to_polar #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int ITERATIONS = r2p_pkg::ITERATIONS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  r2p_in_if.sink    sample,
  r2p_out_if.source result
);

  localparam int XW = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3;
  localparam int SW = 2 * DATA_WIDTH;
  localparam int L  = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;

  logic                      en;
  logic                      v_c    [L+1];
  logic signed [XW-1:0]      x_c    [L+1];
  logic signed [XW-1:0]      y_c    [L+1];
  logic [r2p_pkg::ACC_W-1:0] acc_c  [L+1];
  logic [SW-1:0]             rem_c  [L+1];
  logic [SW-1:0]             root_c [L+1];
  logic [r2p_pkg::QUAD_W-1:0] quad_c [L+1];
  r2p_pkg::result_t          res;

  assign sample.ready = en;

  r2p_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_in(sample.valid),
    .re      (sample.real_part),
    .im      (sample.imag_part),
    .valid   (v_c[0]),
    .x       (x_c[0]),
    .y       (y_c[0]),
    .acc     (acc_c[0]),
    .rem     (rem_c[0]),
    .root    (root_c[0]),
    .quad    (quad_c[0])
  );

  for (genvar i = 0; i < L; i++) begin : g_cell
    r2p_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .ITERATIONS(ITERATIONS),
      .STAGE     (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(v_c[i]),
      .x_in    (x_c[i]),
      .y_in    (y_c[i]),
      .acc_in  (acc_c[i]),
      .rem_in  (rem_c[i]),
      .root_in (root_c[i]),
      .quad_in (quad_c[i]),
      .valid   (v_c[i+1]),
      .x       (x_c[i+1]),
      .y       (y_c[i+1]),
      .acc     (acc_c[i+1]),
      .rem     (rem_c[i+1]),
      .root    (root_c[i+1]),
      .quad    (quad_c[i+1])
    );
  end

  r2p_out #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .up_valid(v_c[L]),
    .up_ready(en),
    .acc     (acc_c[L]),
    .rem     (rem_c[L]),
    .root    (root_c[L]),
    .quad    (quad_c[L]),
    .valid   (result.valid),
    .ready   (result.ready),
    .data    (res)
  );

  assign result.magnitude     = res.magnitude;
  assign result.angle_over_pi = res.angle_over_pi;
  assign result.quadrant      = res.quadrant;

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for rect_to_polar: predicts magnitude, argument and quadrant for each transfer
// and checks every result in order. Depends on r2p_pkg, r2p_in_if, r2p_out_if and the RTL.
`timescale 1ns / 1ps

package polar_tb_pkg;

  localparam int STAGES = 16;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  function automatic r2p_pkg::result_t polar_of(logic signed [15:0] re,
                                                logic signed [15:0] im);
    longint x, y, xs, ys, ar, ai;
    longint unsigned sum, root, probe, rest;
    logic [31:0] turn;
    r2p_pkg::result_t r;
    ar = (re < 0) ? -longint'(re) : longint'(re);
    ai = (im < 0) ? -longint'(im) : longint'(im);
    sum = ar * ar + ai * ai;
    rest = sum;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (sum - root * root > root) root = root + 1;
    r.magnitude = root[15:0];

    if (re == 0 && im == 0) r.quadrant = r2p_pkg::QUAD_ORIGIN;
    else if (re >= 0 && im >= 0) r.quadrant = r2p_pkg::QUAD_1;
    else if (re <= 0 && im >= 0) r.quadrant = r2p_pkg::QUAD_2;
    else if (re <= 0 && im <= 0) r.quadrant = r2p_pkg::QUAD_3;
    else r.quadrant = r2p_pkg::QUAD_4;

    r.angle_over_pi = '0;
    if (r.quadrant != r2p_pkg::QUAD_ORIGIN) begin
      x = longint'(re) * 65536;
      y = longint'(im) * 65536;
      turn = 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        turn = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          turn = turn + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          turn = turn - ATAN_STEP[i];
        end
      end
      turn = turn + 32'h0000_8000;
      r.angle_over_pi = turn[31:16];
    end
    return r;
  endfunction

  class polar_board;
    r2p_pkg::result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_input(logic signed [15:0] re, logic signed [15:0] im);
      pending.push_back(polar_of(re, im));
    endfunction

    function void check_result(logic [r2p_pkg::MAG_W-1:0] mag,
                               logic [r2p_pkg::ANGLE_W-1:0] ang,
                               logic [r2p_pkg::QUAD_W-1:0] quad);
      r2p_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: magnitude %0d angle_over_pi %0d quadrant %0d",
               mag, ang, quad);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (mag !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, mag);
        errors++;
      end
      if (ang !== want.angle_over_pi) begin
        $error("angle_over_pi: expected %0d, got %0d", want.angle_over_pi, ang);
        errors++;
      end
      if (quad !== want.quadrant) begin
        $error("quadrant: expected %0d, got %0d", want.quadrant, quad);
        errors++;
      end
    endfunction
  endclass

endpackage

module tb;

  typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} load_phase_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  load_phase_t phase;
  int hold_left;
  logic held;
  polar_tb_pkg::polar_board board;

  r2p_in_if #(.DATA_WIDTH(16)) sample_ch ();
  r2p_out_if result_ch ();

  rect_to_polar #(
    .DATA_WIDTH(16),
    .ITERATIONS(polar_tb_pkg::STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      board.note_input(sample_ch.real_part, sample_ch.imag_part);
    if (!rst && result_ch.valid && result_ch.ready)
      board.check_result(result_ch.magnitude, result_ch.angle_over_pi, result_ch.quadrant);
  end

  // receiver: random stalls by phase, one long hold-off when free running starts
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == PH_FREE && !held) begin
      result_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held <= 1'b1;
    end else begin
      case (phase)
        PH_SLOW_SINK: result_ch.ready <= ($urandom_range(99) >= 80);
        PH_SLOW_SOURCE: result_ch.ready <= ($urandom_range(99) >= 14);
        default: result_ch.ready <= 1'b1;
      endcase
    end
  end

  function automatic int source_idle_pct(load_phase_t p);
    case (p)
      PH_SLOW_SINK: return 14;
      PH_SLOW_SOURCE: return 80;
      default: return 0;
    endcase
  endfunction

  task automatic send_item(input logic signed [15:0] re, input logic signed [15:0] im);
    while ($urandom_range(99) < source_idle_pct(phase)) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.real_part <= re;
    sample_ch.imag_part <= im;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic send_random(input int count);
    logic signed [15:0] re, im;
    int kind;
    repeat (count) begin
      kind = int'($urandom_range(99));
      re = 16'($urandom);
      im = 16'($urandom);
      if (kind < 15) begin
        re = 16'(int'($urandom_range(8)) - 4);
        im = 16'(int'($urandom_range(8)) - 4);
      end else if (kind < 25) begin
        if ($urandom_range(1)) re = '0;
        else im = '0;
      end else if (kind < 40) begin
        // just below the positive real axis, or either side of the real axis at any real part
        im = 16'(int'($urandom_range(64)) - 32);
        if (kind < 33) begin
          re = 16'($urandom_range(32767, 1));
          im = 16'(-int'($urandom_range(64)));
        end
      end
      send_item(re, im);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    phase = PH_SLOW_SINK;
    hold_left = 0;
    held = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.real_part = '0;
    sample_ch.imag_part = '0;
    result_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(0, 0);
    send_item(32767, 0);
    send_item(-32768, 0);
    send_item(0, 32767);
    send_item(0, -32768);
    send_item(-32768, -32768);
    send_item(32767, 32767);
    send_item(-32768, 32767);
    send_item(32767, -32768);
    send_item(1, 0);
    send_item(-1, 0);
    send_item(0, 1);
    send_item(0, -1);
    send_item(1, 1);
    send_item(-1, 1);
    send_item(-1, -1);
    send_item(1, -1);
    send_item(32767, -1);
    send_item(32767, 1);
    send_item(-32768, -1);
    send_item(-32768, 1);
    send_item(3, 4);
    send_item(-3, -4);

    send_random(270);
    phase <= PH_SLOW_SOURCE;
    send_random(270);
    phase <= PH_FREE;
    send_random(260);
    sample_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
